// ===== src/tcp_receive_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// tcp_receive_sequencer_unit_macros
// Assertion helpers shared by the receive sequencer modules.
// ----------------------------------------------------------------------------
// Every module that uses them names its clock i_clk and its reset i_rst_n.
`ifndef TCP_RECEIVE_SEQUENCER_UNIT_MACROS_SVH
`define TCP_RECEIVE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TCPRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCPRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcprs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcprs_pkg
// Types, codes and defaults of the TCP receive sequencer.
// ----------------------------------------------------------------------------
package tcprs_pkg;

    localparam int          CONN_SLOTS_DEF  = 4;
    localparam int          QUEUE_DEPTH_DEF = 32;
    localparam logic [31:0] RESET_SEQ       = 32'd1001;
    localparam int          PEND_W          = 6;

    // Result status codes
    localparam logic [3:0] ST_QUEUED   = 4'd0;
    localparam logic [3:0] ST_SEQ_DROP = 4'd1;
    localparam logic [3:0] ST_FIN      = 4'd2;
    localparam logic [3:0] ST_SYN      = 4'd3;
    localparam logic [3:0] ST_UNKNOWN  = 4'd4;
    localparam logic [3:0] ST_NO_ENTRY = 4'd5;
    localparam logic [3:0] ST_POLL_OK  = 4'd6;
    localparam logic [3:0] ST_EMPTY    = 4'd7;
    localparam logic [3:0] ST_NO_CONN  = 4'd8;
    localparam logic [3:0] ST_FULL     = 4'd9;
    localparam logic [3:0] ST_OVERFLOW = 4'd10;

    // Input commands
    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_POLL    = 1'b1;

    // Slot table operations
    localparam logic [2:0] SLOT_OP_NONE  = 3'd0;
    localparam logic [2:0] SLOT_OP_OPEN  = 3'd1;
    localparam logic [2:0] SLOT_OP_CLOSE = 3'd2;
    localparam logic [2:0] SLOT_OP_PUSH  = 3'd3;
    localparam logic [2:0] SLOT_OP_POP   = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [15:0] local_port;
        logic [15:0] peer_port;
        logic [31:0] peer_ip;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic        flag_ack;
        logic        flag_syn;
        logic        flag_fin;
        logic        flag_psh;
        logic [15:0] payload_len;
        logic [15:0] packet_handle;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        status;
        logic              send_reply;
        logic              reply_fin;
        logic [31:0]       reply_seq;
        logic [31:0]       reply_ack;
        logic [15:0]       reply_src_port;
        logic [15:0]       reply_dst_port;
        logic [31:0]       reply_dst_ip;
        logic [15:0]       out_handle;
        logic [PEND_W-1:0] pending_count;
        logic              established;
    } t_out_item;

    // Lookup flags from the slot table
    typedef struct packed {
        logic hit;
        logic vacancy;
        logic established;
    } t_slot_look;

endpackage

// ===== src/tcprs_ram.sv =====
// ----------------------------------------------------------------------------
// tcprs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcprs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/tcprs_slot_table.sv =====
// ----------------------------------------------------------------------------
// tcprs_slot_table
// Associative port table: per slot valid, port, established, ring head, count.
// ----------------------------------------------------------------------------
`include "tcp_receive_sequencer_unit_macros.svh"

module tcprs_slot_table
    import tcprs_pkg::*;
#(
    parameter int CONN_SLOTS  = CONN_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int SW = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1,
    localparam int HW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_port,
    output t_slot_look    o_look,
    output logic [SW-1:0] o_hit_idx,
    output logic [SW-1:0] o_free_idx,
    output logic [HW-1:0] o_head,
    output logic [CW-1:0] o_count,
    input  logic [2:0]    i_op,
    input  logic [SW-1:0] i_op_idx
);

    logic              r_valid [CONN_SLOTS];
    logic [15:0]       r_port  [CONN_SLOTS];
    logic              r_est   [CONN_SLOTS];
    logic [HW-1:0]     r_head  [CONN_SLOTS];
    logic [CW-1:0]     r_count [CONN_SLOTS];
    logic [CONN_SLOTS-1:0] match_vec;

    // First matching slot and lowest free slot
    always_comb begin
        o_look     = '0;
        o_hit_idx  = '0;
        o_free_idx = '0;
        match_vec  = '0;
        for (int i = CONN_SLOTS - 1; i >= 0; i--) begin
            match_vec[i] = r_valid[i] && (r_port[i] == i_port);
            if (match_vec[i]) begin
                o_look.hit = 1'b1;
                o_hit_idx  = SW'(i);
            end
            if (!r_valid[i]) begin
                o_look.vacancy = 1'b1;
                o_free_idx     = SW'(i);
            end
        end
        o_look.established = o_look.hit && r_est[o_hit_idx];
    end

    assign o_head  = r_head[o_hit_idx];
    assign o_count = r_count[o_hit_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CONN_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_port[i]  <= '0;
                r_est[i]   <= 1'b0;
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            case (i_op)
                SLOT_OP_OPEN: begin
                    r_valid[i_op_idx] <= 1'b1;
                    r_port[i_op_idx]  <= i_port;
                    r_est[i_op_idx]   <= 1'b1;
                    r_head[i_op_idx]  <= '0;
                    r_count[i_op_idx] <= '0;
                end
                SLOT_OP_CLOSE: begin
                    r_valid[i_op_idx] <= 1'b0;
                    r_est[i_op_idx]   <= 1'b0;
                    r_head[i_op_idx]  <= '0;
                    r_count[i_op_idx] <= '0;
                end
                SLOT_OP_PUSH: begin
                    r_count[i_op_idx] <= r_count[i_op_idx] + CW'(1);
                end
                SLOT_OP_POP: begin
                    // advance head, wrap at ring end
                    if (r_head[i_op_idx] == HW'(QUEUE_DEPTH - 1)) begin
                        r_head[i_op_idx] <= '0;
                    end else begin
                        r_head[i_op_idx] <= r_head[i_op_idx] + HW'(1);
                    end
                    r_count[i_op_idx] <= r_count[i_op_idx] - CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    `TCPRS_ASSERT_IMP(a_port_unique, 1'b1, $countones(match_vec) <= 1,
        "port held by two slots")
    `TCPRS_ASSERT_IMP(a_open_new, i_op == SLOT_OP_OPEN, !o_look.hit && o_look.vacancy,
        "open on existing port or full table")
    `TCPRS_ASSERT_IMP(a_ring_bounds, i_op == SLOT_OP_PUSH || i_op == SLOT_OP_POP,
        o_look.hit && i_op_idx == o_hit_idx && o_count <= CW'(QUEUE_DEPTH),
        "ring access outside a live slot")

endmodule

// ===== src/tcp_receive_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tcp_receive_sequencer_unit
// Sequence tracking, port table and per-port handle rings for received TCP.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one parsed segment or poll
// request per item; output channel (o_out_valid / i_out_ready) returns exactly
// one result item for each. The configuration channel (i_cfg_valid /
// o_cfg_ready) writes the initial sequence number and loads the local
// sequence at once; it is ready whenever reset is released.
// The lookup state reads the port table and reads or writes the handle ring
// memory; the emit state takes the registered ring read data into the output
// register. Items pass one at a time through the single queue memory; the
// next item is accepted in the cycle the result is loaded.
// Reset: control state, port table and sequence numbers clear at once (local
// sequence to 1001); no channel is ready while reset is held. The ring memory
// needs no clearing since a ring is emptied whenever its slot opens.
// Stall: a result held by the receiver blocks the next result load; the
// block then holds its finished item and accepts nothing new.
// ----------------------------------------------------------------------------
`include "tcp_receive_sequencer_unit_macros.svh"

module tcp_receive_sequencer_unit
    import tcprs_pkg::*;
#(
    parameter int CONN_SLOTS  = CONN_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    localparam int SW = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(CONN_SLOTS * QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_local_seq, n_local_seq;
    logic [31:0] r_exp_seq, n_exp_seq;
    t_in_item    r_item;
    t_out_item   r_res, n_res;
    logic        r_pop;
    t_out_item   r_out;
    logic        r_out_valid;
    t_out_item   emit_res;

    t_slot_look    look;
    logic [SW-1:0] hit_idx, free_idx, op_idx;
    logic [HW-1:0] slot_head;
    logic [CW-1:0] slot_count;
    logic [2:0]    slot_op;

    logic          in_acc, out_free;
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [15:0]   ram_rd_data;

    assign o_cfg_ready = i_rst_n;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = i_rst_n &&
                         ((r_state == S_IDLE) || (r_state == S_EMIT && out_free));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    tcprs_slot_table #(
        .CONN_SLOTS  (CONN_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_slot_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_port     (r_item.local_port),
        .o_look     (look),
        .o_hit_idx  (hit_idx),
        .o_free_idx (free_idx),
        .o_head     (slot_head),
        .o_count    (slot_count),
        .i_op       (slot_op),
        .i_op_idx   (op_idx)
    );

    tcprs_ram #(
        .WIDTH (16),
        .DEPTH (CONN_SLOTS * QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_item.packet_handle),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Decide the item in the lookup cycle
    always_comb begin
        logic          enq;
        logic          reply;
        logic [31:0]   base;
        logic [31:0]   step;
        logic [HW:0]   tail_sum;
        logic [HW-1:0] tail;
        logic [CW-1:0] cnt_after;
        logic          est_after;

        enq         = 1'b0;
        reply       = 1'b0;
        base        = (r_exp_seq == 32'd0) ? r_item.seq_number : r_exp_seq;
        step        = (r_item.payload_len == 16'd0) ? 32'd1 : 32'(r_item.payload_len);
        n_local_seq = r_local_seq;
        n_exp_seq   = r_exp_seq;
        slot_op     = SLOT_OP_NONE;
        op_idx      = hit_idx;
        n_res       = '0;

        if (r_item.cmd == CMD_POLL) begin
            if (!look.hit) begin
                n_res.status = ST_NO_CONN;
            end else if (slot_count == '0) begin
                n_res.status = ST_EMPTY;
            end else begin
                n_res.status = ST_POLL_OK;
                slot_op      = SLOT_OP_POP;
            end
        end else if (r_item.flag_ack) begin
            if (r_exp_seq != r_item.seq_number && r_exp_seq != 32'd0) begin
                n_res.status = ST_SEQ_DROP;
            end else begin
                n_local_seq = r_item.ack_number;
                n_exp_seq   = base;
                if (r_item.flag_fin) begin
                    n_exp_seq       = base + step;
                    reply           = 1'b1;
                    n_res.reply_fin = 1'b1;
                    n_res.status    = ST_FIN;
                    if (look.hit) begin
                        slot_op = SLOT_OP_CLOSE;
                    end
                end else if (r_item.flag_syn) begin
                    n_exp_seq    = base + step;
                    reply        = 1'b1;
                    n_res.status = ST_SYN;
                    if (!look.hit) begin
                        if (look.vacancy) begin
                            slot_op = SLOT_OP_OPEN;
                            op_idx  = free_idx;
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                end else if (r_item.flag_psh) begin
                    n_exp_seq = base + 32'(r_item.payload_len);
                    if (!look.hit) begin
                        n_res.status = ST_UNKNOWN;
                    end else begin
                        reply = 1'b1;
                        enq   = 1'b1;
                    end
                end else begin
                    enq = 1'b1;
                end
            end
        end else begin
            enq = 1'b1;
        end

        if (enq) begin
            if (!look.hit) begin
                n_res.status = ST_NO_ENTRY;
            end else if (slot_count == CW'(QUEUE_DEPTH)) begin
                n_res.status = ST_OVERFLOW;
            end else begin
                n_res.status = ST_QUEUED;
                slot_op      = SLOT_OP_PUSH;
            end
        end

        // Ring tail: head + count, wrapped once
        tail_sum = {1'b0, slot_head} + (HW + 1)'(slot_count);
        if (tail_sum >= (HW + 1)'(QUEUE_DEPTH)) begin
            tail = HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH));
        end else begin
            tail = HW'(tail_sum);
        end

        ram_wr_en   = (r_state == S_LOOK) && (slot_op == SLOT_OP_PUSH);
        ram_rd_en   = (r_state == S_LOOK) && (slot_op == SLOT_OP_POP);
        ram_wr_addr = AW'(hit_idx) * AW'(QUEUE_DEPTH) + AW'(tail);
        ram_rd_addr = AW'(hit_idx) * AW'(QUEUE_DEPTH) + AW'(slot_head);
        if (r_state != S_LOOK) begin
            slot_op = SLOT_OP_NONE;
        end

        // Table view after the step
        case (slot_op)
            SLOT_OP_OPEN: begin
                cnt_after = '0;
                est_after = 1'b1;
            end
            SLOT_OP_CLOSE: begin
                cnt_after = '0;
                est_after = 1'b0;
            end
            SLOT_OP_PUSH: begin
                cnt_after = slot_count + CW'(1);
                est_after = look.established;
            end
            SLOT_OP_POP: begin
                cnt_after = slot_count - CW'(1);
                est_after = look.established;
            end
            default: begin
                cnt_after = look.hit ? slot_count : '0;
                est_after = look.established;
            end
        endcase

        n_res.send_reply = reply;
        if (!reply) begin
            n_res.reply_fin = 1'b0;
        end
        n_res.reply_seq      = reply ? n_local_seq : 32'd0;
        n_res.reply_ack      = reply ? n_exp_seq : 32'd0;
        n_res.reply_src_port = reply ? r_item.local_port : 16'd0;
        n_res.reply_dst_port = reply ? r_item.peer_port : 16'd0;
        n_res.reply_dst_ip   = reply ? r_item.peer_ip : 32'd0;
        n_res.pending_count  = PEND_W'(cnt_after);
        n_res.established    = est_after;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = in_acc ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Attach the ring read data to the finished item
    always_comb begin
        emit_res            = r_res;
        emit_res.out_handle = r_pop ? ram_rd_data : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_local_seq <= RESET_SEQ;
            r_exp_seq   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_local_seq <= i_cfg_data;
            end else if (r_state == S_LOOK) begin
                r_local_seq <= n_local_seq;
            end
            if (r_state == S_LOOK) begin
                r_exp_seq <= n_exp_seq;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_item;
        end
        if (r_state == S_LOOK) begin
            r_res <= n_res;
            r_pop <= (slot_op == SLOT_OP_POP);
        end
        if (r_state == S_EMIT && out_free) begin
            r_out <= emit_res;
        end
    end

    `TCPRS_ASSERT_NXT(a_read_then_emit, ram_rd_en, r_state == S_EMIT && r_pop,
        "ring read not followed by result load")
    `TCPRS_ASSERT_IMP(a_pop_nonempty, ram_rd_en,
        look.hit && slot_count != '0 && !ram_wr_en, "pop from empty ring")
    `TCPRS_ASSERT_IMP(a_push_room, ram_wr_en,
        look.hit && slot_count < CW'(QUEUE_DEPTH), "push into full ring")
    `TCPRS_ASSERT_NXT(a_emit_loads, r_state == S_EMIT && out_free, r_out_valid,
        "finished item not loaded")

endmodule
